// ===== hdl/tcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-circuit pixel merge: shared definitions
// Types, register indexes and fixed constants used by the merge datapath.
// ----------------------------------------------------------------------------
package tcpm_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgCircuitEnable    = 3'd0,
    CfgAlphaFromReg     = 3'd1,
    CfgBackgroundOnly   = 3'd2,
    CfgConstantAlpha    = 3'd3,
    CfgBackgroundColor  = 3'd4,
    CfgCircuit1Format   = 3'd5,
    CfgCircuit2Format   = 3'd6
  } cfg_idx_e;

  // Framebuffer word formats. Code three behaves as 16-bit.
  typedef enum logic [1:0] {
    FmtWord32 = 2'd0,
    FmtWord24 = 2'd1,
    FmtWord16 = 2'd2
  } fmt_e;

  // Nonzero pixel count saturates at the largest frame area or at the counter maximum, whichever is smaller.
  localparam int unsigned      CountW    = 23;
  localparam longint unsigned  MaxSide   = 2048;
  localparam logic [63:0]      MaxSideSq = 64'(MaxSide) * 64'(MaxSide);
  localparam logic [63:0]      CountMax  = {{(64-CountW){1'b0}}, {CountW{1'b1}}};
  localparam logic [CountW-1:0] CountLimit =
    (MaxSideSq > CountMax) ? CountMax[CountW-1:0] : MaxSideSq[CountW-1:0];

  // One classified pixel, handed from the front end to the blend pipeline.
  // An uncovered circuit one is carried as alpha zero, which yields the base.
  typedef struct packed {
    logic [23:0] src_rgb;
    logic [23:0] base_rgb;
    logic [7:0]  alpha;
    logic        last;
  } item_t;

endpackage

// ===== hdl/tcpm_front.sv =====
// ----------------------------------------------------------------------------
// Two-circuit pixel merge: front end
// Holds the configuration registers, accepts pixel transactions, converts
// both framebuffer words and resolves base colour and blend alpha.
// ----------------------------------------------------------------------------
module tcpm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcpm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    front_word_i,
  input  logic                           front_present_i,
  input  logic [31:0]                    back_word_i,
  input  logic                           back_present_i,
  input  logic                           frame_last_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output tcpm_pkg::item_t                push_data_o
);

  localparam logic [7:0] AlphaCap    = 8'd128;
  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaHalf   = 8'h80;

  logic [1:0]  enable_q;
  logic        alpha_reg_q;
  logic        bg_only_q;
  logic [7:0]  const_alpha_q;
  logic [23:0] bg_color_q;
  logic [1:0]  c1_fmt_q;
  logic [1:0]  c2_fmt_q;

  logic            valid_q, valid_d;
  tcpm_pkg::item_t item_q, item_d;
  logic            load;

  logic        front_on, back_on;
  logic [31:0] src_word, back_conv;
  logic [7:0]  alpha_raw, alpha_cap;

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [31:0] convert_word(logic [1:0] fmt, logic [31:0] w);
    logic [31:0] res;
    unique case (fmt)
      tcpm_pkg::FmtWord32: res = w;
      tcpm_pkg::FmtWord24: res = {AlphaOpaque, w[23:0]};
      default: begin
        res = {(w[15] ? AlphaOpaque : AlphaHalf),
               widen5(w[14:10]), widen5(w[9:5]), widen5(w[4:0])};
      end
    endcase
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= '0;
      alpha_reg_q   <= 1'b0;
      bg_only_q     <= 1'b0;
      const_alpha_q <= '0;
      bg_color_q    <= '0;
      c1_fmt_q      <= '0;
      c2_fmt_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcpm_pkg::CfgCircuitEnable:   enable_q      <= cfg_data_i[1:0];
        tcpm_pkg::CfgAlphaFromReg:    alpha_reg_q   <= cfg_data_i[0];
        tcpm_pkg::CfgBackgroundOnly:  bg_only_q     <= cfg_data_i[0];
        tcpm_pkg::CfgConstantAlpha:   const_alpha_q <= cfg_data_i[7:0];
        tcpm_pkg::CfgBackgroundColor: bg_color_q    <= cfg_data_i[23:0];
        tcpm_pkg::CfgCircuit1Format:  c1_fmt_q      <= cfg_data_i[1:0];
        tcpm_pkg::CfgCircuit2Format:  c2_fmt_q      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    front_on  = enable_q[0] & front_present_i;
    back_on   = enable_q[1] & back_present_i;
    src_word  = convert_word(c1_fmt_q, front_word_i);
    back_conv = convert_word(c2_fmt_q, back_word_i);
    alpha_raw = alpha_reg_q ? const_alpha_q : src_word[31:24];
    alpha_cap = (alpha_raw > AlphaCap) ? AlphaCap : alpha_raw;

    item_d.src_rgb  = src_word[23:0];
    item_d.base_rgb = (!bg_only_q && back_on) ? back_conv[23:0] : bg_color_q;
    item_d.alpha    = front_on ? alpha_cap : '0;
    item_d.last     = frame_last_i;
  end

  // The stage refills whenever its content moves on to the queue.
  assign load       = !valid_q || push_ready_i;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = item_q;

endmodule

// ===== hdl/tcpm_queue.sv =====
// ----------------------------------------------------------------------------
// Two-circuit pixel merge: decoupling queue
// Small first-in first-out buffer between the front end and the blend pipeline.
// ----------------------------------------------------------------------------
module tcpm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tcpm_pkg::item_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tcpm_pkg::item_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tcpm_pkg::item_t       slots_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/tcpm_back.sv =====
// ----------------------------------------------------------------------------
// Two-circuit pixel merge: blend pipeline
// Blends circuit one over the base colour, then counts nonzero pixels and
// presents the result in an output register.
// ----------------------------------------------------------------------------
module tcpm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  tcpm_pkg::item_t               pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [23:0]                   color_rgb_o,
  output logic                          pixel_nonzero_o,
  output logic [tcpm_pkg::CountW-1:0]   nonzero_total_o,
  output logic                          frame_done_o
);

  localparam logic [7:0]  AlphaFull = 8'd128;
  localparam logic [15:0] RoundBias = 16'd64;

  // Blend stage.
  logic        mix_valid_q;
  logic [23:0] mix_rgb_q, mix_rgb_d;
  logic        mix_last_q;
  logic        mix_load;
  logic [7:0]  inv_alpha;
  logic [15:0] acc;

  // Output stage.
  logic                        out_valid_q;
  logic [23:0]                 out_rgb_q;
  logic                        out_nz_q;
  logic [tcpm_pkg::CountW-1:0] out_total_q;
  logic                        out_last_q;
  logic                        out_load;

  logic [tcpm_pkg::CountW-1:0] count_q, count_d;
  logic [tcpm_pkg::CountW-1:0] total;
  logic                        nz;

  always_comb begin
    inv_alpha = AlphaFull - pop_data_i.alpha;
    mix_rgb_d = '0;
    acc       = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 16'(pop_data_i.src_rgb[8*ch +: 8]) * 16'(pop_data_i.alpha)
          + 16'(pop_data_i.base_rgb[8*ch +: 8]) * 16'(inv_alpha)
          + RoundBias;
      // The weights sum to 128, so the shifted value never exceeds 255.
      mix_rgb_d[8*ch +: 8] = acc[14:7];
    end
  end

  assign out_load    = !out_valid_q || !out_stall_i;
  assign mix_load    = !mix_valid_q || out_load;
  assign pop_ready_o = mix_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q <= 1'b0;
    end else if (mix_load) begin
      mix_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_load && pop_valid_i) begin
      mix_rgb_q  <= mix_rgb_d;
      mix_last_q <= pop_data_i.last;
    end
  end

  always_comb begin
    nz      = (mix_rgb_q != '0);
    total   = (nz && count_q < tcpm_pkg::CountLimit) ?
              count_q + tcpm_pkg::CountW'(1) : count_q;
    count_d = count_q;
    if (out_load && mix_valid_q) begin
      count_d = mix_last_q ? '0 : total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= mix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && mix_valid_q) begin
      out_rgb_q   <= mix_rgb_q;
      out_nz_q    <= nz;
      out_total_q <= total;
      out_last_q  <= mix_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign color_rgb_o     = out_rgb_q;
  assign pixel_nonzero_o = out_nz_q;
  assign nonzero_total_o = out_total_q;
  assign frame_done_o    = out_last_q;

endmodule

// ===== hdl/two_circuit_pixel_merge.sv =====
// ----------------------------------------------------------------------------
// Two-circuit pixel merge
// Merges two display circuits per pixel position over a background colour
// and keeps a per-frame count of nonzero output pixels.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   front_word, front_present,
//                                                back_word, back_present,
//                                                frame_last
//  out      output     out_valid_o / out_stall_i color_rgb, pixel_nonzero,
//                                                nonzero_total, frame_done
//  cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One pixel transaction is accepted per cycle while in_stall_o is low; a result
// passes through the front register, queue, blend register and output register.
// Reset clears configuration, the counter and all valid flags; no clearing pass.
// Either side may stall independently; the queue of QUEUE_DEPTH entries
// absorbs the difference, and input stalls only once it and the front
// register are full.
// ----------------------------------------------------------------------------
module two_circuit_pixel_merge #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcpm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   front_word_i,
  input  logic                          front_present_i,
  input  logic [31:0]                   back_word_i,
  input  logic                          back_present_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [23:0]                   color_rgb_o,
  output logic                          pixel_nonzero_o,
  output logic [tcpm_pkg::CountW-1:0]  nonzero_total_o,
  output logic                          frame_done_o
);

  logic            push_valid, push_ready;
  tcpm_pkg::item_t push_data;
  logic            pop_valid, pop_ready;
  tcpm_pkg::item_t pop_data;

  tcpm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .front_word_i    (front_word_i),
    .front_present_i (front_present_i),
    .back_word_i     (back_word_i),
    .back_present_i  (back_present_i),
    .frame_last_i    (frame_last_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  tcpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tcpm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .color_rgb_o     (color_rgb_o),
    .pixel_nonzero_o (pixel_nonzero_o),
    .nonzero_total_o (nonzero_total_o),
    .frame_done_o    (frame_done_o)
  );

endmodule
